@@ sv/triangle_overlap_test_2d_unit_macros.svh @@
// Assertion macros for the triangle overlap test unit.
// The macros expect clk and rst_n in scope where they are used.
`ifndef TRIANGLE_OVERLAP_TEST_2D_UNIT_MACROS_SVH
`define TRIANGLE_OVERLAP_TEST_2D_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define TOT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TOT_ASSERT_SAME(label, ante, cons, msg)
`define TOT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ sv/tot_pkg.sv @@
// Shared types and constants for the triangle overlap test unit.
// No dependencies; used by tot_lane, tot_merge and the top level.
package tot_pkg;

    // Coordinate width of every vertex component.
    localparam int CoordBits = 16;
    localparam int NumCoords = 12;
    localparam int NumAxes   = 6;
    localparam int NumVerts  = 6;

    // Stream data widths, rounded up to whole bytes.
    localparam int InBits  = ((NumCoords * CoordBits + 7) / 8) * 8;
    localparam int OutBits = 8;

    typedef logic signed [CoordBits-1:0]   coord_t;
    typedef logic signed [CoordBits:0]     axis_t;
    typedef logic signed [2*CoordBits:0]   prod_t;
    typedef logic signed [2*CoordBits+1:0] dot_t;

    // Load enables handed from the top-level pipeline control to each lane.
    typedef struct packed {
        logic ld_prod;
        logic ld_dot;
        logic ld_sep;
    } tot_ctrl_t;

endpackage

@@ sv/tot_lane.sv @@
// One separating-axis lane: projects both triangles on one axis and flags separation.
// Depends on tot_pkg.
module tot_lane
    import tot_pkg::*;
(
    input  logic      clk,
    input  tot_ctrl_t ctrl,
    input  axis_t     ax_x,
    input  axis_t     ax_y,
    input  coord_t    verts [NumCoords],
    output logic      sep
);

    prod_t px_reg  [NumVerts];
    prod_t py_reg  [NumVerts];
    dot_t  dot_reg [NumVerts];
    dot_t  dot_next [NumVerts];
    logic  sep_reg;
    logic  sep_next;
    dot_t  min_a;
    dot_t  max_a;
    dot_t  min_b;
    dot_t  max_b;

    function automatic dot_t min3(input dot_t p, input dot_t q, input dot_t r);
        dot_t m;
        m = (q < p) ? q : p;
        return (r < m) ? r : m;
    endfunction

    function automatic dot_t max3(input dot_t p, input dot_t q, input dot_t r);
        dot_t m;
        m = (p < q) ? q : p;
        return (m < r) ? r : m;
    endfunction

    // Products of every vertex component with the axis.
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_prod)
        begin
            for (int j = 0; j < NumVerts; j++)
            begin
                px_reg[j] <= prod_t'(verts[2*j]) * prod_t'(ax_x);
                py_reg[j] <= prod_t'(verts[2*j+1]) * prod_t'(ax_y);
            end
        end
    end

    // Dot products, one per vertex.
    always_comb
    begin
        for (int j = 0; j < NumVerts; j++)
        begin
            dot_next[j] = dot_t'(px_reg[j]) + dot_t'(py_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_dot)
        begin
            dot_reg <= dot_next;
        end
    end

    // Interval bounds and the strict disjointness test.
    always_comb
    begin
        min_a    = min3(dot_reg[0], dot_reg[1], dot_reg[2]);
        max_a    = max3(dot_reg[0], dot_reg[1], dot_reg[2]);
        min_b    = min3(dot_reg[3], dot_reg[4], dot_reg[5]);
        max_b    = max3(dot_reg[3], dot_reg[4], dot_reg[5]);
        sep_next = (max_a < min_b) || (max_b < min_a);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_sep)
        begin
            sep_reg <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

@@ sv/tot_merge.sv @@
// Merge stage: combines the separation flags of all lanes into the output register.
// Depends on tot_pkg.
module tot_merge
    import tot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [NumAxes-1:0] sep_vec,
    input  logic               sep_valid,
    input  logic               out_ready,
    output logic               ready,
    output logic               out_valid,
    output logic               hit
);

    logic valid_reg;
    logic valid_next;
    logic hit_reg;

    // The output register takes a new result when empty or being drained.
    assign ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = ready ? sep_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // A hit unless some axis separates the triangles.
    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            hit_reg <= ~|sep_vec;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;

endmodule

@@ sv/triangle_overlap_test_2d_unit.sv @@
// Triangle overlap test top level: input register, axis stage, six lanes and merge.
// Depends on tot_pkg, tot_lane, tot_merge and triangle_overlap_test_2d_unit_macros.svh.
//
// Tests two 2D triangles for overlap with the separating axis test on the six
// unnormalized edge perpendiculars; touching intervals count as a hit. The unit
// takes one triangle pair per clock cycle when the output side is not stalled.
// The stages are: input register, axis computation, products, dot products,
// interval test, and the output register. Six lanes, one per axis, each with
// twelve multipliers, carry that rate. Stages fill bubbles independently, so a
// stalled output still lets new transfers enter until the pipeline is full.
`include "triangle_overlap_test_2d_unit_macros.svh"

module triangle_overlap_test_2d_unit
    import tot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // Fields from bit 0 up: a_vert0_x, a_vert0_y, a_vert1_x, a_vert1_y,
    // a_vert2_x, a_vert2_y, b_vert0_x, b_vert0_y, b_vert1_x, b_vert1_y,
    // b_vert2_x, b_vert2_y.
    input  logic [InBits-1:0]  s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // Fields from bit 0 up: hit, then zero fill.
    output logic [OutBits-1:0] m_tdata
);

    localparam int NumStages = 5;

    logic [NumStages-1:0] v_reg;
    logic [NumStages-1:0] v_next;
    logic [NumStages:0]   rdy;
    coord_t               coord_reg [NumCoords];
    coord_t               vert_reg  [NumCoords];
    axis_t                ax_x_reg  [NumAxes];
    axis_t                ax_y_reg  [NumAxes];
    axis_t                ax_x_next [NumAxes];
    axis_t                ax_y_next [NumAxes];
    logic [NumAxes-1:0]   sep_vec;
    tot_ctrl_t            ctrl;
    logic                 merge_ready;
    logic                 hit;

    // Per-stage ready chain: a stage takes new data when empty or moving on.
    always_comb
    begin
        rdy[NumStages] = merge_ready;
        for (int k = NumStages - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NumStages; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = rdy[0];

    // Input register: unpack the coordinates of the transfer.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < NumCoords; i++)
            begin
                coord_reg[i] <= s_tdata[i*CoordBits +: CoordBits];
            end
        end
    end

    // Edge perpendiculars (-dy, dx) for each edge of both triangles.
    for (genvar l = 0; l < NumAxes; l++)
    begin : g_axis
        localparam int Base = (l / 3) * 6;
        localparam int Cur  = Base + 2 * (l % 3);
        localparam int Nxt  = Base + 2 * ((l % 3 + 1) % 3);

        assign ax_x_next[l] = axis_t'(coord_reg[Cur+1]) - axis_t'(coord_reg[Nxt+1]);
        assign ax_y_next[l] = axis_t'(coord_reg[Nxt]) - axis_t'(coord_reg[Cur]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            ax_x_reg <= ax_x_next;
            ax_y_reg <= ax_y_next;
            vert_reg <= coord_reg;
        end
    end

    assign ctrl.ld_prod = rdy[2];
    assign ctrl.ld_dot  = rdy[3];
    assign ctrl.ld_sep  = rdy[4];

    // One lane per candidate axis.
    for (genvar l = 0; l < NumAxes; l++)
    begin : g_lane
        tot_lane u_lane (
            .clk   (clk),
            .ctrl  (ctrl),
            .ax_x  (ax_x_reg[l]),
            .ax_y  (ax_y_reg[l]),
            .verts (vert_reg),
            .sep   (sep_vec[l])
        );
    end

    tot_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .sep_vec   (sep_vec),
        .sep_valid (v_reg[NumStages-1]),
        .out_ready (m_tready),
        .ready     (merge_ready),
        .out_valid (m_tvalid),
        .hit       (hit)
    );

    assign m_tdata = OutBits'(hit);

    // Checks on the pipeline control.
    `TOT_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with output empty")
    `TOT_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, v_reg[0], "transfer not captured")
    `TOT_ASSERT_NEXT(a_merge_loads, v_reg[NumStages-1] && merge_ready, m_tvalid,
        "result lost at merge")
    `TOT_ASSERT_NEXT(a_hit_no_sep, v_reg[NumStages-1] && merge_ready && (sep_vec == '0),
        m_tdata[0], "hit missing with no separating axis")

endmodule
